// ===== rtl/urpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range presence detect - shared package
// Types, register indexes and fixed constants used across the block.
// ----------------------------------------------------------------------------
`default_nettype none

package urpd_pkg;

  // Measurement phase
  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_TRIGGER   = 2'd1,
    PH_WAIT_RISE = 2'd2,
    PH_MEASURE   = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD_CM   = 2'd0;
  localparam logic [1:0] REG_REQUIRED_READS = 2'd1;
  localparam logic [1:0] REG_TRIGGER_TICKS  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [10:0] RST_THRESHOLD_CM   = 11'd30;
  localparam logic [3:0]  RST_REQUIRED_READS = 4'd2;
  localparam logic [5:0]  RST_TRIGGER_TICKS  = 6'd20;

  // Fixed arithmetic constants
  localparam int unsigned CM_DIVISOR    = 58;
  localparam int unsigned CM_DIV_LOG2   = 6;       // ceil(log2(58))
  localparam logic [10:0] DIST_MAX      = 11'h7FF;
  localparam logic [3:0]  NEAR_MAX      = 4'hF;

  // Configuration set seen by the core
  typedef struct packed {
    logic [10:0] threshold_cm;
    logic [3:0]  required_reads;
    logic [5:0]  trigger_ticks;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic echo_level;
    logic start_request;
  } item_t;

  // One result item
  typedef struct packed {
    logic        trigger_level;
    logic        reading_done;
    logic [10:0] distance_cm;
    logic        object_present;
    logic        busy_res;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/urpd_in_stage.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range presence detect - input register
// Holds one accepted input item until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module urpd_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire urpd_pkg::item_t in_item,
  output logic                item_valid,
  output urpd_pkg::item_t     item,
  input  wire logic           item_take
);
  import urpd_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Take a new item when empty or when the held one leaves this cycle
  assign in_ready = !valid_r || item_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== rtl/urpd_core.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range presence detect - measurement core
// Phase machine, echo counter, divide by 58, near counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module urpd_core #(
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire urpd_pkg::cfg_t  cfg,
  input  wire logic            item_valid,
  input  wire urpd_pkg::item_t item,
  output logic                 item_take,
  output logic                 res_valid,
  output urpd_pkg::result_t    res,
  input  wire logic            res_ready
);
  import urpd_pkg::*;

  // Reciprocal of 58 scaled by 2^RSH, exact for every counter value
  localparam int unsigned RSH    = ECHO_COUNT_BITS + CM_DIV_LOG2;
  localparam int unsigned PW     = ECHO_COUNT_BITS + RSH;
  localparam int unsigned QW     = (ECHO_COUNT_BITS > 11) ? ECHO_COUNT_BITS : 11;
  localparam longint unsigned RECIP_L =
    ((64'd1 << RSH) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam logic [RSH-1:0] RECIP = RECIP_L[RSH-1:0];

  phase_t                     phase_r, phase_nxt;
  logic [5:0]                 pulse_r, pulse_nxt;
  logic [ECHO_COUNT_BITS-1:0] echo_w_r, echo_w_nxt;
  logic [3:0]                 near_r, near_nxt;
  logic [10:0]                dist_r, dist_nxt;
  logic                       done_nxt;
  logic                       res_valid_r;
  result_t                    res_r;

  logic [PW-1:0]              prod;
  logic [QW-1:0]              quot;
  logic [10:0]                dist_new;
  logic                       step;

  // Advance when an item is held and the result slot is free or leaving
  assign step      = item_valid && (!res_valid_r || res_ready);
  assign item_take = step;

  // Divide the echo width by 58 and clamp to the distance field
  assign prod     = PW'(echo_w_r) * PW'(RECIP);
  assign quot     = QW'(prod[PW-1:RSH]);
  assign dist_new = (quot > QW'(DIST_MAX)) ? DIST_MAX : quot[10:0];

  // Next phase and counters
  always_comb begin
    phase_nxt  = phase_r;
    pulse_nxt  = pulse_r;
    echo_w_nxt = echo_w_r;
    near_nxt   = near_r;
    dist_nxt   = dist_r;
    done_nxt   = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (item.start_request) begin
          phase_nxt = PH_TRIGGER;
          pulse_nxt = 6'd1;
        end
      end
      PH_TRIGGER: begin
        if (pulse_r >= cfg.trigger_ticks) begin
          phase_nxt = PH_WAIT_RISE;
          pulse_nxt = '0;
        end else begin
          pulse_nxt = pulse_r + 6'd1;
        end
      end
      PH_WAIT_RISE: begin
        if (item.echo_level) begin
          phase_nxt  = PH_MEASURE;
          echo_w_nxt = ECHO_COUNT_BITS'(1);
        end
      end
      PH_MEASURE: begin
        if (item.echo_level) begin
          // Saturate at the counter's maximum
          if (echo_w_r != '1) begin
            echo_w_nxt = echo_w_r + ECHO_COUNT_BITS'(1);
          end
        end else begin
          dist_nxt = dist_new;
          if (dist_new < cfg.threshold_cm) begin
            if (near_r != NEAR_MAX) begin
              near_nxt = near_r + 4'd1;
            end
          end else begin
            near_nxt = '0;
          end
          echo_w_nxt = '0;
          phase_nxt  = PH_IDLE;
          done_nxt   = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      pulse_r  <= '0;
      echo_w_r <= '0;
      near_r   <= '0;
      dist_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pulse_r  <= pulse_nxt;
      echo_w_r <= echo_w_nxt;
      near_r   <= near_nxt;
      dist_r   <= dist_nxt;
    end
  end

  // Result valid: set on a step, drop when taken with nothing behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // Result payload from this step's updated state
  always_ff @(posedge clk) begin
    if (step) begin
      res_r.trigger_level  <= (phase_nxt == PH_TRIGGER);
      res_r.reading_done   <= done_nxt;
      res_r.distance_cm    <= dist_nxt;
      res_r.object_present <= (near_nxt > cfg.required_reads);
      res_r.busy_res       <= (phase_nxt != PH_IDLE);
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  // A finished reading always returns the block to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.reading_done |-> !res_r.busy_res && !res_r.trigger_level)
    else $error("reading done while still busy");

  // Trigger is driven only within a measurement
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.trigger_level |-> res_r.busy_res)
    else $error("trigger high outside a measurement");

  // The echo counter is never zero while measuring
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_MEASURE |-> echo_w_r != '0)
    else $error("echo width zero while measuring");

  // Idle without a start stays idle
  assert property (@(posedge clk) disable iff (!rst_n)
    step && phase_r == PH_IDLE && !item.start_request |=> phase_r == PH_IDLE)
    else $error("left idle without a start");

  // State only moves on a step
  assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(near_r))
    else $error("state changed without an item");

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_range_presence_detect.sv =====
// ----------------------------------------------------------------------------
// Ultrasonic range presence detect - top level
// Trigger pulse, echo timing, distance in centimetres and presence flag.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_ready    echo_level, start_request
//   out_     output     out_valid/out_ready  trigger_level, reading_done,
//                                            distance_cm, object_present,
//                                            busy_res
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while the output does not stall. Each item gives
// one result through the input register, then the result register behind the
// state update. The divide by 58 is one constant multiply on the echo counter.
// Synchronous active-low reset clears phase, counters and distance, and
// restores the register defaults.
// A stalled output holds its result while one more item waits in the input
// register; input ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_presence_detect #(
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_echo_level,
  input  wire logic        in_start_request,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_trigger_level,
  output logic             out_reading_done,
  output logic [10:0]      out_distance_cm,
  output logic             out_object_present,
  output logic             out_busy_res,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data
);
  import urpd_pkg::*;

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  result_t res;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_cm   <= RST_THRESHOLD_CM;
      cfg_r.required_reads <= RST_REQUIRED_READS;
      cfg_r.trigger_ticks  <= RST_TRIGGER_TICKS;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_THRESHOLD_CM:   cfg_r.threshold_cm   <= cfg_data;
        REG_REQUIRED_READS: cfg_r.required_reads <= cfg_data[3:0];
        REG_TRIGGER_TICKS:  cfg_r.trigger_ticks  <= cfg_data[5:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign in_item.echo_level    = in_echo_level;
  assign in_item.start_request = in_start_request;

  urpd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  urpd_core #(
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (out_valid),
    .res        (res),
    .res_ready  (out_ready)
  );

  assign out_trigger_level  = res.trigger_level;
  assign out_reading_done   = res.reading_done;
  assign out_distance_cm    = res.distance_cm;
  assign out_object_present = res.object_present;
  assign out_busy_res       = res.busy_res;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range presence detect - testbench
// Feeds microsecond tick items through the input handshake and checks every
// result item against a tick-by-tick model of the ranging state machine.
// A short table covers reset, the one-tick trigger and near/far readings. The
// longest trigger pulse and a long echo follow, then random measurements
// under several register settings with random idling, stretches without
// idling and one long output stall that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  import urpd_pkg::*;

  localparam int ECHO_BITS    = 16;
  localparam int HOLD_CYCLES  = 100;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RAND_ITEMS   = 1000;
  localparam int RAND_READS   = 30;
  localparam int LONG_ECHO    = 100;
  localparam int N_DIR        = 20;

  // One row of the directed table: a register write or a tick item
  typedef struct packed {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [10:0] data;
    logic        echo;
    logic        start;
    bit          fixed;
    result_t     res;
  } dir_row_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_echo_level    = 1'b0;
  logic        in_start_request = 1'b0;
  logic        out_ready        = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic [1:0]  cfg_index        = REG_THRESHOLD_CM;
  logic [10:0] cfg_data         = '0;
  logic        in_ready;
  logic        out_valid;
  logic        out_trigger_level;
  logic        out_reading_done;
  logic [10:0] out_distance_cm;
  logic        out_object_present;
  logic        out_busy_res;
  logic        cfg_ready;

  // Model of the ranging state and its register copy
  cfg_t                 shadow_cfg;
  phase_t               m_phase;
  logic [5:0]           m_pulse;
  logic [ECHO_BITS-1:0] m_echo;
  logic [3:0]           m_near;
  logic [10:0]          m_dist;

  result_t  pending_results[$];
  dir_row_t dir_tab [N_DIR];
  int       errors        = 0;
  int       items_sent    = 0;
  int       readings_seen = 0;
  int       stall_cycles  = 0;
  bit       quiet         = 1'b0;
  bit       hold_req      = 1'b0;
  bit       short_echo    = 1'b0;

  ultrasonic_range_presence_detect #(
    .ECHO_COUNT_BITS(ECHO_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_echo_level     (in_echo_level),
    .in_start_request  (in_start_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger_level (out_trigger_level),
    .out_reading_done  (out_reading_done),
    .out_distance_cm   (out_distance_cm),
    .out_object_present(out_object_present),
    .out_busy_res      (out_busy_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic coin();
    return $urandom_range(0, 1) != 0;
  endfunction

  // Advance the model by one tick and return the result item it gives
  function automatic result_t next_ranging_result(logic echo, logic start);
    result_t     r;
    int unsigned quot;
    logic        done;
    done = 1'b0;
    case (m_phase)
      PH_IDLE: begin
        if (start) begin
          m_phase = PH_TRIGGER;
          m_pulse = 6'd1;
        end
      end
      PH_TRIGGER: begin
        // a zero pulse length behaves as one tick
        if (m_pulse >= shadow_cfg.trigger_ticks) begin
          m_phase = PH_WAIT_RISE;
          m_pulse = '0;
        end else begin
          m_pulse = m_pulse + 6'd1;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          m_phase = PH_MEASURE;
          m_echo  = ECHO_BITS'(1);
        end
      end
      default: begin
        if (echo) begin
          // hold at full scale on a long echo
          if (m_echo != '1) m_echo = m_echo + ECHO_BITS'(1);
        end else begin
          quot = m_echo / CM_DIVISOR;
          if (quot > DIST_MAX) quot = DIST_MAX;
          m_dist = quot[10:0];
          if (quot < shadow_cfg.threshold_cm) begin
            if (m_near != NEAR_MAX) m_near = m_near + 4'd1;
          end else begin
            m_near = '0;
          end
          m_echo  = '0;
          m_phase = PH_IDLE;
          done    = 1'b1;
          readings_seen++;
        end
      end
    endcase
    r.trigger_level  = (m_phase == PH_TRIGGER);
    r.reading_done   = done;
    r.distance_cm    = m_dist;
    r.object_present = (m_near > shadow_cfg.required_reads);
    r.busy_res       = (m_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Offer one tick item after a random gap; record its expected result on acceptance
  task automatic send_item(logic echo, logic start, bit fixed = 1'b0,
                           result_t fixed_res = '0);
    int unsigned gap;
    result_t     pred;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_echo_level    <= echo;
    in_start_request <= start;
    do @(posedge clk); while (!in_ready);
    pred = next_ranging_result(echo, start);
    pending_results.push_back(fixed ? fixed_res : pred);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_THRESHOLD_CM:   shadow_cfg.threshold_cm   = data;
      REG_REQUIRED_READS: shadow_cfg.required_reads = data[3:0];
      REG_TRIGGER_TICKS:  shadow_cfg.trigger_ticks  = data[5:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Finish any measurement in flight, then drain every result
  task automatic settle();
    while (m_phase != PH_IDLE) send_item(m_phase == PH_WAIT_RISE, 1'b0);
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly whole measurements with random content; some plain noise
  task automatic run_measurement();
    int unsigned kind;
    int unsigned n;
    int unsigned w;
    int unsigned thr;
    kind = $urandom_range(0, 9);
    if (kind >= 8) begin
      n = $urandom_range(1, 30);
      repeat (n) send_item(coin(), coin());
    end else begin
      send_item(coin(), 1'b1);
      n = (shadow_cfg.trigger_ticks == 0) ? 1 : shadow_cfg.trigger_ticks;
      repeat (n) send_item(coin(), coin());
      n = $urandom_range(0, 4);
      repeat (n) send_item(1'b0, coin());
      // echo width: short, around the threshold, or longer
      thr  = shadow_cfg.threshold_cm;
      kind = $urandom_range(0, 19);
      if (short_echo) begin
        w = $urandom_range(1, 20);
      end else if (kind < 12) begin
        w = $urandom_range(1, 40);
      end else if (kind < 17 && thr <= 6) begin
        w = thr * CM_DIVISOR + $urandom_range(0, 2 * CM_DIVISOR);
        w = (w > CM_DIVISOR) ? w - CM_DIVISOR : 1;
      end else begin
        w = $urandom_range(1, 180);
      end
      repeat (w) send_item(1'b1, coin());
      send_item(1'b0, coin());
    end
  endtask

  // Drop the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Result side: random ready gaps, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    result_t     want;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        if (out_ready) out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result item with none expected, got trig %0b done %0b dist %0d",
                 $time, out_trigger_level, out_reading_done, out_distance_cm);
      end else begin
        want = pending_results.pop_front();
        check_field("trigger_level", want.trigger_level, out_trigger_level);
        check_field("reading_done", want.reading_done, out_reading_done);
        check_field("distance_cm", want.distance_cm, out_distance_cm);
        check_field("object_present", want.object_present, out_object_present);
        check_field("busy_res", want.busy_res, out_busy_res);
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          p;
    int          base_items;
    int          base_reads;
    int          ph_items;
    int          ph_reads;
    int          min_reads;
    logic [10:0] thr_sel;
    logic [3:0]  req_sel;
    logic [5:0]  trig_sel;

    dir_tab = '{
      // idle after reset, echo ignored while idle
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b1, {1'b0, 1'b0, 11'd0, 1'b0, 1'b0}},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b0, 1'b1, {1'b0, 1'b0, 11'd0, 1'b0, 1'b0}},
      // zero pulse length, near below 2 cm, presence after one near reading
      '{1'b1, REG_TRIGGER_TICKS, 11'd0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b1, REG_THRESHOLD_CM, 11'd2, 1'b0, 1'b0, 1'b0, '0},
      '{1'b1, REG_REQUIRED_READS, 11'd0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b1, 1'b1, {1'b1, 1'b0, 11'd0, 1'b0, 1'b1}},
      // echo during trigger and start while busy are ignored
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b1, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b1, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b1, {1'b0, 1'b1, 11'd0, 1'b1, 1'b0}},
      // second near reading
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b1, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b1, {1'b0, 1'b1, 11'd0, 1'b1, 1'b0}},
      // zero threshold: nothing is near, the count clears
      '{1'b1, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b1, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0, REG_THRESHOLD_CM, 11'd0, 1'b0, 1'b0, 1'b1, {1'b0, 1'b1, 11'd0, 1'b0, 1'b0}}
    };

    shadow_cfg = '{RST_THRESHOLD_CM, RST_REQUIRED_READS, RST_TRIGGER_TICKS};
    m_phase    = PH_IDLE;
    m_pulse    = '0;
    m_echo     = '0;
    m_near     = '0;
    m_dist     = '0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].echo, dir_tab[i].start, dir_tab[i].fixed, dir_tab[i].res);
      end
    end

    // Longest pulse, then a long echo, with the pulse length at its top value and the threshold above any distance
    settle();
    write_reg(REG_TRIGGER_TICKS, 11'd63);
    write_reg(REG_THRESHOLD_CM, 11'd1130);
    write_reg(REG_REQUIRED_READS, 11'd14);
    quiet = 1'b1;
    send_item(1'b0, 1'b1);
    repeat (63) send_item(coin(), coin());
    send_item(1'b0, 1'b0);
    repeat (LONG_ECHO) send_item(1'b1, coin());
    send_item(1'b0, 1'b0);
    quiet = 1'b0;

    // Random measurements across register settings
    base_items = items_sent;
    base_reads = readings_seen;
    p = 0;
    while (items_sent - base_items < RAND_ITEMS || readings_seen - base_reads < RAND_READS ||
           p < 6) begin
      settle();
      case (p)
        0: begin
          thr_sel  = 11'd0;
          req_sel  = 4'd0;
          trig_sel = 6'd1;
        end
        1: begin
          thr_sel  = 11'd1130;
          req_sel  = 4'd14;
          trig_sel = 6'd1;
        end
        2: begin
          thr_sel  = 11'd1023;
          req_sel  = 4'd7;
          trig_sel = 6'd63;
        end
        default: begin
          thr_sel  = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 1130))
                                                 : 11'($urandom_range(0, 4));
          req_sel  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 14))
                                                 : 4'($urandom_range(0, 3));
          trig_sel = 6'($urandom_range(0, 10));
        end
      endcase
      write_reg(REG_THRESHOLD_CM, thr_sel);
      write_reg(REG_REQUIRED_READS, {7'd0, req_sel});
      write_reg(REG_TRIGGER_TICKS, {5'd0, trig_sel});
      // stall the result side for a long stretch while items keep coming
      if (p == 0) hold_req = 1'b1;
      quiet      = (p % 4 == 3);
      // short echoes give enough near readings in a row to saturate the count
      short_echo = (p == 1);
      min_reads  = (p == 1) ? 16 : 2;
      ph_items   = items_sent;
      ph_reads   = readings_seen;
      while (items_sent - ph_items < 80 || readings_seen - ph_reads < min_reads) begin
        run_measurement();
      end
      quiet      = 1'b0;
      short_echo = 1'b0;
      p++;
    end

    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/urpd_pkg.sv
rtl/urpd_in_stage.sv
rtl/urpd_core.sv
rtl/ultrasonic_range_presence_detect.sv
tb/testbench.sv
